/* sv/assert_macros.svh */
// assertion macros used by the checker of the heater controller
// no dependencies; every macro reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked property with an active-low reset disable
`define DPHP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DPHP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `DPHP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define DPHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `DPHP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* sv/dphp_pkg.sv */
// shared types and constants of the dual pi heater pwm controller
// no dependencies; used by the top level and its checker
package dphp_pkg;

  // stream and register port widths
  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 80;
  localparam int unsigned ADDR_W = 5;

  // boost rule threshold in centidegrees
  localparam logic [15:0] BOOST_THRESHOLD = 16'd6000;

  // division by 25: multiply by ceil(2^34 / 25) and keep bits above 34
  localparam logic [29:0] RECIP_MUL   = 30'd687194768;
  localparam int unsigned RECIP_SHIFT = 34;

  // register reset values
  localparam logic [15:0] RST_TARGET      = 16'd0;
  localparam logic [15:0] RST_PROP_GAIN   = 16'd0;
  localparam logic [15:0] RST_INTEG_GAIN  = 16'd0;
  localparam logic [23:0] RST_INTEG_UPPER = 24'h7FFFFF;
  localparam logic [23:0] RST_INTEG_LOWER = 24'h800000;
  localparam logic [7:0]  RST_PWM_PERIOD  = 8'd100;
  localparam logic [15:0] RST_ALARM_CODE  = 16'hFFFF;

  // register indexes, byte address is four times the index
  typedef enum logic [2:0] {
    REG_TARGET      = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_INTEG_UPPER = 3'd3,
    REG_INTEG_LOWER = 3'd4,
    REG_PWM_PERIOD  = 3'd5,
    REG_ALARM_CODE  = 3'd6
  } reg_idx_e;

  // per-tick control that travels alongside the arithmetic
  typedef struct packed {
    logic       en;
    logic       alarm_one;
    logic       alarm_two;
    logic       boost;
    logic [7:0] phase;
  } ctl_t;

endpackage

/* sv/dual_pi_heater_pwm_unit.sv */
// top level of the dual pi heater pwm controller: stream in, stream out, apb registers
// depends on dphp_pkg
//
// One transaction on the input stream is one control tick and yields exactly one result
// transaction. The block sustains one tick per clock cycle while results are not held on
// m_axis_tready: the phase counter, boost flag and both clamped integrators are updated in
// the cycle the tick is accepted, and the drive arithmetic follows in a five-register
// pipeline (input register, gain products, sum and magnitude with the divide by 1024 as a
// shift, reciprocal multiply for the divide by 25, result register). The pipeline stalls
// stage by stage, so new ticks keep entering while a finished result waits on
// m_axis_tready, until all five registers hold a tick. Configuration writes are taken
// through the apb port, pready is always high, and registers should only be written while
// no tick is in flight.
module dual_pi_heater_pwm_unit #(
  parameter logic [15:0] BOOST_THRESHOLD = dphp_pkg::BOOST_THRESHOLD
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [0] measure_enable, [16:1] reading_one, [32:17] reading_two, [39:33] zero
  input  logic [dphp_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] heater_one_on, [1] heater_two_on, [2] boost_request, [34:3] drive_one,
  // [66:35] drive_two, [74:67] pwm_phase, [79:75] zero
  output logic [dphp_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dphp_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // configuration registers
  logic [15:0] target_q;
  logic [15:0] prop_gain_q;
  logic [15:0] integ_gain_q;
  logic [23:0] integ_upper_q;
  logic [23:0] integ_lower_q;
  logic [7:0]  pwm_period_q;
  logic [15:0] alarm_code_q;

  // controller state
  logic [7:0]  phase_q, phase_d;
  logic [23:0] integ_q [2];
  logic [23:0] integ_d [2];
  logic        boost_q, boost_d;
  logic        heater_q [2];
  logic        heater_d [2];

  // pipeline valids and stage enables
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, en_o;
  logic accept;

  // pipeline payload
  dphp_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  dphp_pkg::ctl_t ctl_d;
  logic signed [16:0] err_d   [2];
  logic signed [16:0] err1_q  [2];
  logic        [23:0] sum_d   [2];
  logic signed [23:0] sum1_q  [2];
  logic signed [32:0] pprod_d [2];
  logic signed [39:0] iprod_d [2];
  logic signed [32:0] pprod_q [2];
  logic signed [39:0] iprod_q [2];
  logic signed [39:0] total   [2];
  logic        [39:0] mag     [2];
  logic        [28:0] mag_q   [2];
  logic               neg3_q  [2];
  logic        [58:0] recip   [2];
  logic        [24:0] quo_q   [2];
  logic               neg4_q  [2];
  logic        [31:0] drive_d [2];
  logic        [31:0] drive_q [2];
  logic               boost_o_q;
  logic        [7:0]  phase_o_q;

  // front-end working values
  logic        [15:0] reading [2];
  logic               alarm   [2];
  logic signed [24:0] sum25   [2];
  logic        [7:0]  phase_inc;
  logic               meas_en;

  // apb register write and read
  logic                 cfg_wr;
  dphp_pkg::reg_idx_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = dphp_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= dphp_pkg::RST_TARGET;
      prop_gain_q   <= dphp_pkg::RST_PROP_GAIN;
      integ_gain_q  <= dphp_pkg::RST_INTEG_GAIN;
      integ_upper_q <= dphp_pkg::RST_INTEG_UPPER;
      integ_lower_q <= dphp_pkg::RST_INTEG_LOWER;
      pwm_period_q  <= dphp_pkg::RST_PWM_PERIOD;
      alarm_code_q  <= dphp_pkg::RST_ALARM_CODE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dphp_pkg::REG_TARGET:      target_q      <= pwdata[15:0];
        dphp_pkg::REG_PROP_GAIN:   prop_gain_q   <= pwdata[15:0];
        dphp_pkg::REG_INTEG_GAIN:  integ_gain_q  <= pwdata[15:0];
        dphp_pkg::REG_INTEG_UPPER: integ_upper_q <= pwdata[23:0];
        dphp_pkg::REG_INTEG_LOWER: integ_lower_q <= pwdata[23:0];
        dphp_pkg::REG_PWM_PERIOD:  pwm_period_q  <= pwdata[7:0];
        dphp_pkg::REG_ALARM_CODE:  alarm_code_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dphp_pkg::REG_TARGET:      prdata = {16'd0, target_q};
      dphp_pkg::REG_PROP_GAIN:   prdata = {{16{prop_gain_q[15]}}, prop_gain_q};
      dphp_pkg::REG_INTEG_GAIN:  prdata = {{16{integ_gain_q[15]}}, integ_gain_q};
      dphp_pkg::REG_INTEG_UPPER: prdata = {{8{integ_upper_q[23]}}, integ_upper_q};
      dphp_pkg::REG_INTEG_LOWER: prdata = {{8{integ_lower_q[23]}}, integ_lower_q};
      dphp_pkg::REG_PWM_PERIOD:  prdata = {24'd0, pwm_period_q};
      dphp_pkg::REG_ALARM_CODE:  prdata = {16'd0, alarm_code_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // stage enables: a stage loads when it is empty or its content moves on
  assign en_o          = !vo_q || m_axis_tready;
  assign en4           = !v4_q || en_o;
  assign en3           = !v3_q || en4;
  assign en2           = !v2_q || en3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front end: phase, boost and clamped integrators for the tick being accepted
  assign meas_en    = s_axis_tdata[0];
  assign reading[0] = s_axis_tdata[16:1];
  assign reading[1] = s_axis_tdata[32:17];
  assign phase_inc  = phase_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    boost_d = boost_q;
    if (accept) begin
      if (!meas_en) begin
        phase_d = 8'd0;
      end else begin
        phase_d = (phase_inc >= pwm_period_q) ? 8'd0 : phase_inc;
        if (target_q > BOOST_THRESHOLD) begin
          boost_d = 1'b1;
        end else if (target_q < BOOST_THRESHOLD) begin
          boost_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      alarm[c] = (reading[c] == alarm_code_q);
      err_d[c] = $signed({1'b0, target_q}) - $signed({1'b0, reading[c]});
      sum25[c] = $signed({integ_q[c][23], integ_q[c]}) + $signed({{8{err_d[c][16]}}, err_d[c]});
      if (sum25[c] > $signed({integ_upper_q[23], integ_upper_q})) begin
        sum_d[c] = integ_upper_q;
      end else if (sum25[c] < $signed({integ_lower_q[23], integ_lower_q})) begin
        sum_d[c] = integ_lower_q;
      end else begin
        sum_d[c] = sum25[c][23:0];
      end
      integ_d[c] = integ_q[c];
      if (accept) begin
        if (!meas_en) begin
          integ_d[c] = 24'd0;
        end else if (!alarm[c]) begin
          integ_d[c] = sum_d[c];
        end
      end
    end
  end

  always_comb begin
    ctl_d.en        = meas_en;
    ctl_d.alarm_one = alarm[0];
    ctl_d.alarm_two = alarm[1];
    ctl_d.boost     = boost_d;
    ctl_d.phase     = phase_d;
  end

  // gain products
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      pprod_d[c] = err1_q[c] * $signed(prop_gain_q);
      iprod_d[c] = sum1_q[c] * $signed(integ_gain_q);
    end
  end

  // sum, sign and magnitude, divide by 256 and by 4 as a shift
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      total[c] = $signed({{7{pprod_q[c][32]}}, pprod_q[c]}) + iprod_q[c];
      mag[c]   = total[c][39] ? 40'(-total[c]) : total[c];
    end
  end

  // divide by 25 through the reciprocal
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      recip[c] = {30'd0, mag_q[c]} * {29'd0, dphp_pkg::RECIP_MUL};
    end
  end

  // signed drive, heater decision against the phase
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      drive_d[c] = neg4_q[c] ? 32'(-{7'd0, quo_q[c]}) : {7'd0, quo_q[c]};
    end
    if (ctl4_q.en && !ctl4_q.alarm_one) begin
      heater_d[0] = $signed(drive_d[0]) > $signed({24'd0, ctl4_q.phase});
    end else begin
      heater_d[0] = ctl4_q.en ? 1'b0 : heater_q[0];
      drive_d[0]  = 32'd0;
    end
    if (ctl4_q.en && !ctl4_q.alarm_two) begin
      heater_d[1] = $signed(drive_d[1]) > $signed({24'd0, ctl4_q.phase});
    end else begin
      heater_d[1] = ctl4_q.en ? 1'b0 : heater_q[1];
      drive_d[1]  = 32'd0;
    end
  end

  // control state and valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 8'd0;
      boost_q     <= 1'b0;
      integ_q[0]  <= 24'd0;
      integ_q[1]  <= 24'd0;
      heater_q[0] <= 1'b0;
      heater_q[1] <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      vo_q        <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      boost_q    <= boost_d;
      integ_q[0] <= integ_d[0];
      integ_q[1] <= integ_d[1];
      if (en_o && v4_q) begin
        heater_q[0] <= heater_d[0];
        heater_q[1] <= heater_d[1];
      end
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en_o) vo_q <= v4_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctl1_q <= ctl_d;
      for (int c = 0; c < 2; c++) begin
        err1_q[c] <= err_d[c];
        sum1_q[c] <= sum_d[c];
      end
    end
    if (en2 && v1_q) begin
      ctl2_q <= ctl1_q;
      for (int c = 0; c < 2; c++) begin
        pprod_q[c] <= pprod_d[c];
        iprod_q[c] <= iprod_d[c];
      end
    end
    if (en3 && v2_q) begin
      ctl3_q <= ctl2_q;
      for (int c = 0; c < 2; c++) begin
        mag_q[c]  <= mag[c][38:10];
        neg3_q[c] <= total[c][39];
      end
    end
    if (en4 && v3_q) begin
      ctl4_q <= ctl3_q;
      for (int c = 0; c < 2; c++) begin
        quo_q[c]  <= recip[c][dphp_pkg::RECIP_SHIFT +: 25];
        neg4_q[c] <= neg3_q[c];
      end
    end
    if (en_o && v4_q) begin
      drive_q[0] <= drive_d[0];
      drive_q[1] <= drive_d[1];
      boost_o_q  <= ctl4_q.boost;
      phase_o_q  <= ctl4_q.phase;
    end
  end

  // result stream
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {5'd0, phase_o_q, drive_q[1], drive_q[0], boost_o_q,
                          heater_q[1], heater_q[0]};

endmodule

/* sv/dphp_checker.sv */
// port-level checker for the dual pi heater pwm controller, bound to the top level
// depends on dphp_pkg and assert_macros.svh
`include "assert_macros.svh"

module dphp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dphp_pkg::OUT_W-1:0]  m_axis_tdata
);

  // result fields
  logic        heat_one, heat_two;
  logic [31:0] drv_one, drv_two;
  logic [31:0] phase_ext;

  assign heat_one  = m_axis_tdata[0];
  assign heat_two  = m_axis_tdata[1];
  assign drv_one   = m_axis_tdata[34:3];
  assign drv_two   = m_axis_tdata[66:35];
  assign phase_ext = {24'd0, m_axis_tdata[74:67]};

  // a stalled result keeps its payload
  `DPHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // an empty output register never blocks the input side
  `DPHP_ASSERT_IMPL(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

  // a live drive on channel one decides its heater against the phase
  `DPHP_ASSERT_IMPL(a_heat_one, clk_i, rst_ni, m_axis_tvalid && (drv_one != 32'd0), heat_one == ($signed(drv_one) > $signed(phase_ext)), "channel one heater disagrees with drive")

  // same rule on channel two
  `DPHP_ASSERT_IMPL(a_heat_two, clk_i, rst_ni, m_axis_tvalid && (drv_two != 32'd0), heat_two == ($signed(drv_two) > $signed(phase_ext)), "channel two heater disagrees with drive")

endmodule

bind dual_pi_heater_pwm_unit dphp_checker u_dphp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/tb.sv */
// testbench of dual_pi_heater_pwm_unit: a directed table of register writes and control ticks,
// then randomized tick streams checked against a cycle-free model of the two pi channels
// depends on dphp_pkg and dual_pi_heater_pwm_unit
module tb;

  localparam longint DRIVE_DIV    = 25600;
  localparam longint DRIVE_MAX    = 64'sd2147483647;
  localparam longint DRIVE_MIN    = -64'sd2147483648;
  localparam int     RAND_PHASES  = 12;
  localparam int     PHASE_TICKS  = 150;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     HOLD_AT      = 700;
  localparam int     HOLD_CYCLES  = 300;

  // one control tick as packed into s_axis_tdata
  typedef struct packed {
    logic [15:0] rd_two;
    logic [15:0] rd_one;
    logic        en;
  } heat_tick_t;

  // one result as packed into m_axis_tdata
  typedef struct packed {
    logic [7:0]         phase;
    logic signed [31:0] drive_two;
    logic signed [31:0] drive_one;
    logic               boost;
    logic               heat_two;
    logic               heat_one;
  } heat_res_t;

  typedef enum logic {ROW_WRITE, ROW_TICK} plan_kind_e;

  typedef struct {
    plan_kind_e         kind;
    dphp_pkg::reg_idx_e idx;
    logic [31:0]        val;
    heat_tick_t         tick;
    bit                 typed;
    heat_res_t          res;
  } plan_row_t;

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        s_valid = 1'b0;
  logic [dphp_pkg::IN_W-1:0]   s_data  = '0;
  logic                        s_ready;
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [dphp_pkg::OUT_W-1:0]  m_data;
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [dphp_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // controller model: configuration copy
  logic [15:0]        cfg_target = dphp_pkg::RST_TARGET;
  logic signed [15:0] cfg_kp     = dphp_pkg::RST_PROP_GAIN;
  logic signed [15:0] cfg_ki     = dphp_pkg::RST_INTEG_GAIN;
  logic signed [23:0] cfg_upper  = dphp_pkg::RST_INTEG_UPPER;
  logic signed [23:0] cfg_lower  = dphp_pkg::RST_INTEG_LOWER;
  logic [7:0]         cfg_period = dphp_pkg::RST_PWM_PERIOD;
  logic [15:0]        cfg_alarm  = dphp_pkg::RST_ALARM_CODE;

  // controller model: state
  logic [7:0]         st_phase    = '0;
  logic signed [23:0] st_integ [2] = '{24'sd0, 24'sd0};
  logic               st_heat [2]  = '{1'b0, 1'b0};
  logic               st_boost    = 1'b0;

  heat_res_t          pending_results [$];
  plan_row_t          plan [$];
  dphp_pkg::reg_idx_e all_regs [7] = '{
    dphp_pkg::REG_TARGET, dphp_pkg::REG_PROP_GAIN, dphp_pkg::REG_INTEG_GAIN,
    dphp_pkg::REG_INTEG_UPPER, dphp_pkg::REG_INTEG_LOWER, dphp_pkg::REG_PWM_PERIOD,
    dphp_pkg::REG_ALARM_CODE
  };
  int        mismatch_count = 0;
  int        results_seen   = 0;
  bit        quiet_tail     = 1'b0;
  bit        long_hold_done = 1'b0;

  dual_pi_heater_pwm_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one pi channel: clamped integrator, truncating divide, saturation, heater compare
  function automatic logic signed [31:0] run_pi(int ch, logic [15:0] rd);
    longint err;
    longint acc;
    longint drv;
    err = longint'(cfg_target) - longint'(rd);
    acc = longint'(st_integ[ch]) + err;
    if (acc > longint'(cfg_upper)) acc = longint'(cfg_upper);
    else if (acc < longint'(cfg_lower)) acc = longint'(cfg_lower);
    st_integ[ch] = acc[23:0];
    drv = (err * longint'(cfg_kp) + acc * longint'(cfg_ki)) / DRIVE_DIV;
    if (drv > DRIVE_MAX) drv = DRIVE_MAX;
    if (drv < DRIVE_MIN) drv = DRIVE_MIN;
    st_heat[ch] = drv > longint'(st_phase);
    return drv[31:0];
  endfunction

  // advance the model by one tick and form its result
  function automatic heat_res_t compute_heater_result(heat_tick_t t);
    heat_res_t r;
    r.drive_one = '0;
    r.drive_two = '0;
    if (t.en) begin
      st_phase = st_phase + 8'd1;
      if (st_phase >= cfg_period) st_phase = '0;
      if (cfg_target > dphp_pkg::BOOST_THRESHOLD) st_boost = 1'b1;
      else if (cfg_target < dphp_pkg::BOOST_THRESHOLD) st_boost = 1'b0;
      // a failed sensor forces its heater off and freezes its integrator
      if (t.rd_one != cfg_alarm) r.drive_one = run_pi(0, t.rd_one);
      else st_heat[0] = 1'b0;
      if (t.rd_two != cfg_alarm) r.drive_two = run_pi(1, t.rd_two);
      else st_heat[1] = 1'b0;
    end else begin
      st_phase    = '0;
      st_integ[0] = '0;
      st_integ[1] = '0;
    end
    r.heat_one = st_heat[0];
    r.heat_two = st_heat[1];
    r.boost    = st_boost;
    r.phase    = st_phase;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void plan_write(dphp_pkg::reg_idx_e idx, logic [31:0] val);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.idx   = idx;
    row.val   = val;
    row.tick  = '0;
    row.typed = 1'b0;
    row.res   = '0;
    plan.push_back(row);
  endfunction

  function automatic void plan_tick(logic en, logic [15:0] r1, logic [15:0] r2);
    plan_row_t row;
    row.kind        = ROW_TICK;
    row.idx         = dphp_pkg::REG_TARGET;
    row.val         = '0;
    row.tick.en     = en;
    row.tick.rd_one = r1;
    row.tick.rd_two = r2;
    row.typed       = 1'b0;
    row.res         = '0;
    plan.push_back(row);
  endfunction

  // pins the result of the last tick row to a hand-derived value
  function automatic void plan_typed(logic h1, logic h2, logic boost, logic signed [31:0] d1,
                                     logic signed [31:0] d2, logic [7:0] phase);
    plan[$].typed         = 1'b1;
    plan[$].res.heat_one  = h1;
    plan[$].res.heat_two  = h2;
    plan[$].res.boost     = boost;
    plan[$].res.drive_one = d1;
    plan[$].res.drive_two = d2;
    plan[$].res.phase     = phase;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 25;
      default: return 50;
    endcase
  endfunction

  // readings mostly sit near the setpoint so the loop stays in its working range
  function automatic logic [15:0] pick_reading();
    int unsigned sel;
    int          near;
    sel  = $urandom_range(0, 99);
    near = int'(cfg_target) + int'($urandom_range(0, 800)) - 400;
    if (sel < 6) return cfg_alarm;
    else if (sel < 20) return 16'($urandom);
    else return near[15:0];
  endfunction

  function automatic heat_tick_t rand_tick();
    heat_tick_t t;
    t.en     = ($urandom_range(0, 99) >= 5);
    t.rd_one = pick_reading();
    t.rd_two = pick_reading();
    return t;
  endfunction

  // register values biased toward the extremes
  function automatic logic [31:0] pick_reg_value(dphp_pkg::reg_idx_e idx);
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(0, 7);
    v   = $urandom;
    case (idx)
      dphp_pkg::REG_TARGET: begin
        case (sel)
          0: v = 32'h0;
          1: v = 32'hFFFF;
          2: v = 32'(dphp_pkg::BOOST_THRESHOLD);
          3: v = 32'(dphp_pkg::BOOST_THRESHOLD) + 32'd1;
          4: v = 32'(dphp_pkg::BOOST_THRESHOLD) - 32'd1;
          default: ;
        endcase
        v = v & 32'hFFFF;
      end
      dphp_pkg::REG_PROP_GAIN, dphp_pkg::REG_INTEG_GAIN: begin
        case (sel)
          0: v = 32'h8000;
          1: v = 32'h7FFF;
          2: ;
          default: begin
            if (idx == dphp_pkg::REG_PROP_GAIN) v = 32'($urandom_range(0, 16384)) - 32'd8192;
            else v = 32'($urandom_range(0, 128)) - 32'd64;
          end
        endcase
        v = v & 32'hFFFF;
      end
      dphp_pkg::REG_INTEG_UPPER: begin
        case (sel)
          0: v = 32'h7FFFFF;
          1: v = 32'h800000;
          2: ;
          default: v = 32'($urandom_range(0, 300000));
        endcase
        v = v & 32'hFFFFFF;
      end
      dphp_pkg::REG_INTEG_LOWER: begin
        case (sel)
          0: v = 32'h800000;
          1: v = 32'h7FFFFF;
          2: ;
          default: v = 32'd0 - 32'($urandom_range(0, 300000));
        endcase
        v = v & 32'hFFFFFF;
      end
      dphp_pkg::REG_PWM_PERIOD: begin
        case (sel)
          0: v = 32'd255;
          1: v = 32'd1;
          2: v = 32'd0;
          default: v = 32'($urandom_range(2, 254));
        endcase
        v = v & 32'hFF;
      end
      dphp_pkg::REG_ALARM_CODE: begin
        case (sel)
          0: v = 32'hFFFF;
          1: v = 32'h0;
          default: ;
        endcase
        v = v & 32'hFFFF;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // apb write, issued only once every pending result is out
  task automatic write_reg(dphp_pkg::reg_idx_e idx, logic [31:0] val);
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dphp_pkg::REG_TARGET:      cfg_target = val[15:0];
      dphp_pkg::REG_PROP_GAIN:   cfg_kp     = val[15:0];
      dphp_pkg::REG_INTEG_GAIN:  cfg_ki     = val[15:0];
      dphp_pkg::REG_INTEG_UPPER: cfg_upper  = val[23:0];
      dphp_pkg::REG_INTEG_LOWER: cfg_lower  = val[23:0];
      dphp_pkg::REG_PWM_PERIOD:  cfg_period = val[7:0];
      dphp_pkg::REG_ALARM_CODE:  cfg_alarm  = val[15:0];
      default: ;
    endcase
  endtask

  // offer one tick, hold it until accepted, then queue its expected result
  task automatic send_tick(heat_tick_t t, bit typed, heat_res_t typed_res);
    heat_res_t r;
    s_valid <= 1'b1;
    s_data  <= dphp_pkg::IN_W'(t);
    do @(posedge clk_i); while (!s_ready);
    r = compute_heater_result(t);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_sender(int pct);
    if (!quiet_tail && $urandom_range(0, 99) < pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    heat_res_t got;
    heat_res_t want;
    if (rst_ni && m_valid && m_ready) begin
      results_seen++;
      got = m_data[$bits(heat_res_t)-1:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("heater_one_on", want.heat_one, got.heat_one);
        check_field("heater_two_on", want.heat_two, got.heat_two);
        check_field("boost_request", want.boost, got.boost);
        check_field("drive_one", want.drive_one, got.drive_one);
        check_field("drive_two", want.drive_two, got.drive_two);
        check_field("pwm_phase", want.phase, got.phase);
      end
    end
  end

  // result sink: random stall bursts, one long hold-off, none in the tail
  initial begin : result_sink
    int rx_pct;
    int cyc;
    rx_pct = 0;
    cyc    = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (cyc % 100 == 0) rx_pct = pick_idle_pct();
      if (!long_hold_done && !quiet_tail && results_seen >= HOLD_AT) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 99) < rx_pct) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
      cyc++;
    end
  end

  // stimulus
  initial begin : stimulus
    heat_res_t none;
    int        tx_pct;
    none   = '0;
    tx_pct = 0;

    // state right after reset, alarm on the reset code, disabled tick
    plan_tick(1'b1, 16'h0000, 16'h0000);
    plan_typed(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0, 8'd1);
    plan_tick(1'b1, 16'hFFFF, 16'hFFFE);
    plan_typed(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0, 8'd2);
    plan_tick(1'b0, 16'h1234, 16'hFFFF);
    plan_typed(1'b0, 1'b0, 1'b0, 32'sd0, 32'sd0, 8'd0);
    // unity proportional gain: drive is error over 100, boost sets
    plan_write(dphp_pkg::REG_TARGET, 32'd10000);
    plan_write(dphp_pkg::REG_PROP_GAIN, 32'h0100);
    plan_tick(1'b1, 16'd0, 16'd10000);
    plan_typed(1'b1, 1'b0, 1'b1, 32'sd100, 32'sd0, 8'd1);
    // disabled tick holds heaters and boost
    plan_tick(1'b0, 16'd0, 16'd0);
    plan_typed(1'b1, 1'b0, 1'b1, 32'sd0, 32'sd0, 8'd0);
    // target at the threshold holds boost, gains at their extremes
    plan_write(dphp_pkg::REG_TARGET, 32'(dphp_pkg::BOOST_THRESHOLD));
    plan_write(dphp_pkg::REG_PROP_GAIN, 32'h8000);
    plan_write(dphp_pkg::REG_INTEG_GAIN, 32'h7FFF);
    plan_tick(1'b1, 16'h0000, 16'hFFFE);
    plan_tick(1'b1, 16'hFFFE, 16'h0000);
    // narrow clamps, lower one reached
    plan_write(dphp_pkg::REG_TARGET, 32'd0);
    plan_write(dphp_pkg::REG_INTEG_UPPER, 32'h000100);
    plan_write(dphp_pkg::REG_INTEG_LOWER, 32'hFFFF00);
    plan_tick(1'b1, 16'hFFFE, 16'h0000);
    // alarm code zero on both channels, then upper clamp
    plan_write(dphp_pkg::REG_TARGET, 32'hFFFF);
    plan_write(dphp_pkg::REG_ALARM_CODE, 32'h0);
    plan_tick(1'b1, 16'h0000, 16'h0000);
    plan_typed(1'b0, 1'b0, 1'b1, 32'sd0, 32'sd0, 8'd4);
    plan_tick(1'b1, 16'h0001, 16'hFFFF);
    // crossed clamps
    plan_write(dphp_pkg::REG_INTEG_UPPER, 32'hFFFF00);
    plan_write(dphp_pkg::REG_INTEG_LOWER, 32'h000100);
    plan_tick(1'b1, 16'h0005, 16'hFFFF);
    plan_write(dphp_pkg::REG_TARGET, 32'd0);
    plan_tick(1'b1, 16'hFFFE, 16'h0001);
    // period shrunk below the running phase, then period one
    plan_write(dphp_pkg::REG_PWM_PERIOD, 32'd1);
    plan_tick(1'b1, 16'h0002, 16'h0003);
    plan_tick(1'b1, 16'h8000, 16'h7FFF);
    // zero period
    plan_write(dphp_pkg::REG_PWM_PERIOD, 32'd0);
    plan_tick(1'b1, 16'h1111, 16'h2222);
    plan_tick(1'b1, 16'hFFFF, 16'h0000);
    // widest period and clamps, opposite gain extremes
    plan_write(dphp_pkg::REG_PWM_PERIOD, 32'd255);
    plan_write(dphp_pkg::REG_INTEG_UPPER, 32'h7FFFFF);
    plan_write(dphp_pkg::REG_INTEG_LOWER, 32'h800000);
    plan_write(dphp_pkg::REG_ALARM_CODE, 32'hFFFF);
    plan_write(dphp_pkg::REG_PROP_GAIN, 32'h7FFF);
    plan_write(dphp_pkg::REG_INTEG_GAIN, 32'h8000);
    plan_write(dphp_pkg::REG_TARGET, 32'hFFFF);
    plan_tick(1'b1, 16'h0000, 16'h0000);
    plan_tick(1'b1, 16'h0000, 16'hFFFF);
    plan_tick(1'b1, 16'hAAAA, 16'h5555);
    plan_tick(1'b0, 16'h5555, 16'hAAAA);

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].res);
        idle_sender(25);
      end
    end

    // random phases, each with a fresh register mix; the write drains the pipeline first
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) quiet_tail = 1'b1;
      foreach (all_regs[r]) begin
        if ($urandom_range(0, 1) == 1) write_reg(all_regs[r], pick_reg_value(all_regs[r]));
      end
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (k % 50 == 0) tx_pct = pick_idle_pct();
        send_tick(rand_tick(), 1'b0, none);
        idle_sender(tx_pct);
      end
    end

    // drain and finish
    s_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
